@@ rtl/core/tcol_pkg.sv @@
// Shared widths, region codes and the divider side-band word for the triangle/circle core.
package tcol_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned RadBits   = CoordBits - 1;
  localparam int unsigned DiffBits  = CoordBits + 1;
  localparam int unsigned MulBits   = 2 * DiffBits;
  localparam int unsigned ProdBits  = MulBits + 1;
  localparam int unsigned NumBits   = ProdBits + 2;
  localparam int unsigned QuoBits   = 32;
  localparam int unsigned FracBits  = QuoBits + 1;

  localparam logic [2:0] RegA  = 3'd0;
  localparam logic [2:0] RegB  = 3'd1;
  localparam logic [2:0] RegC  = 3'd2;
  localparam logic [2:0] RegAb = 3'd3;
  localparam logic [2:0] RegAc = 3'd4;
  localparam logic [2:0] RegBc = 3'd5;
  localparam logic [2:0] RegIn = 3'd6;

  // Everything that rides next to the quotient through the divider.
  typedef struct packed {
    logic                        ins;
    logic [2:0]                  region;
    logic                        full;
    logic                        zero;
    logic signed [CoordBits-1:0] base_x;
    logic signed [CoordBits-1:0] base_y;
    logic signed [DiffBits-1:0]  e_x;
    logic signed [DiffBits-1:0]  e_y;
    logic signed [CoordBits-1:0] p_x;
    logic signed [CoordBits-1:0] p_y;
    logic [RadBits-1:0]          radius;
  } pay_t;

  function automatic logic signed [MulBits-1:0] mul_diff(
    input logic signed [DiffBits-1:0] a,
    input logic signed [DiffBits-1:0] b
  );
    return a * b;
  endfunction

  function automatic logic signed [ProdBits-1:0] cross2(
    input logic signed [DiffBits-1:0] a,
    input logic signed [DiffBits-1:0] b,
    input logic signed [DiffBits-1:0] c,
    input logic signed [DiffBits-1:0] d
  );
    return ProdBits'(mul_diff(a, b)) - ProdBits'(mul_diff(c, d));
  endfunction

  function automatic logic signed [ProdBits-1:0] dot2(
    input logic signed [DiffBits-1:0] a,
    input logic signed [DiffBits-1:0] b,
    input logic signed [DiffBits-1:0] c,
    input logic signed [DiffBits-1:0] d
  );
    return ProdBits'(mul_diff(a, b)) + ProdBits'(mul_diff(c, d));
  endfunction

endpackage

@@ rtl/core/tcol_div.sv @@
// Pipelined restoring divider giving a 32-bit fraction num/den, one quotient bit per stage.
module tcol_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [tcol_pkg::NumBits-1:0] num_i,
  input  logic [tcol_pkg::NumBits-1:0] den_i,
  input  tcol_pkg::pay_t       pay_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [tcol_pkg::QuoBits-1:0] quo_o,
  output tcol_pkg::pay_t       pay_o
);

  localparam int unsigned Stages = tcol_pkg::QuoBits;
  localparam int unsigned NW     = tcol_pkg::NumBits;

  logic                         v_q   [Stages];
  logic [NW-1:0]                rem_q [Stages];
  logic [NW-1:0]                den_q [Stages];
  logic [tcol_pkg::QuoBits-1:0] quo_q [Stages];
  tcol_pkg::pay_t               pay_q [Stages];
  logic                         rdy   [Stages+1];

  assign rdy[Stages] = out_ready_i;

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    logic                         v_in;
    logic [NW-1:0]                rem_in;
    logic [NW-1:0]                den_in;
    logic [tcol_pkg::QuoBits-1:0] quo_in;
    tcol_pkg::pay_t               pay_in;
    logic [NW:0]                  sh;
    logic                         ge;

    if (i == 0) begin : g_first
      assign v_in   = in_valid_i;
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign pay_in = pay_i;
    end else begin : g_next
      assign v_in   = v_q[i-1];
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
      assign pay_in = pay_q[i-1];
    end

    assign rdy[i] = !v_q[i] || rdy[i+1];
    assign sh     = {rem_in, 1'b0};
    assign ge     = sh >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i] && v_in) begin
        rem_q[i] <= ge ? NW'(sh - {1'b0, den_in}) : sh[NW-1:0];
        den_q[i] <= den_in;
        quo_q[i] <= {quo_in[tcol_pkg::QuoBits-2:0], ge};
        pay_q[i] <= pay_in;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[Stages-1];
  assign quo_o       = quo_q[Stages-1];
  assign pay_o       = pay_q[Stages-1];

endmodule

@@ rtl/core/triangle_circle_overlap_2d_core.sv @@
// Top level of the triangle/circle overlap core: closest point on a triangle and radius test.
// Throughput: one word per cycle while out_ready_i is high; every stage carries its own valid
// bit and holds its data when the stage after it cannot load, so bubbles collapse and stalls lose nothing.
// The depth is set by the 32-stage fraction divider, one quotient bit per stage.
// Reset clears only the valid bits; data registers are not reset.
module triangle_circle_overlap_2d_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [tcol_pkg::CoordBits-1:0]   vert_a_x_i,
  input  logic signed [tcol_pkg::CoordBits-1:0]   vert_a_y_i,
  input  logic signed [tcol_pkg::CoordBits-1:0]   vert_b_x_i,
  input  logic signed [tcol_pkg::CoordBits-1:0]   vert_b_y_i,
  input  logic signed [tcol_pkg::CoordBits-1:0]   vert_c_x_i,
  input  logic signed [tcol_pkg::CoordBits-1:0]   vert_c_y_i,
  input  logic signed [tcol_pkg::CoordBits-1:0]   center_x_i,
  input  logic signed [tcol_pkg::CoordBits-1:0]   center_y_i,
  input  logic [tcol_pkg::RadBits-1:0]            radius_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    overlap_o,
  output logic                                    inside_res_o,
  output logic signed [tcol_pkg::CoordBits-1:0]   near_x_o,
  output logic signed [tcol_pkg::CoordBits-1:0]   near_y_o,
  output logic [2:0]                              region_o
);

  localparam int unsigned W  = tcol_pkg::CoordBits;
  localparam int unsigned DW = tcol_pkg::DiffBits;
  localparam int unsigned PW = tcol_pkg::ProdBits;
  localparam int unsigned NW = tcol_pkg::NumBits;
  localparam int unsigned FW = tcol_pkg::FracBits;
  localparam int unsigned QW = tcol_pkg::QuoBits;
  localparam int unsigned XW = W + FW;        // width of |e| * f
  localparam int unsigned OW = XW + 1 - QW;   // rounded offset width
  localparam int unsigned SW = 2 * W;         // one squared distance term

  // Handshake chain: a stage may load when it is empty or its successor loads.
  logic v1_q, v2_q, v3_q, vm1_q, vm2_q, vm3_q, vo_q;
  logic rdy1, rdy2, rdy3, rdym1, rdym2, rdym3, rdyo;
  logic div_in_ready, div_out_valid;

  assign rdyo  = !vo_q  || out_ready_i;
  assign rdym3 = !vm3_q || rdyo;
  assign rdym2 = !vm2_q || rdym3;
  assign rdym1 = !vm1_q || rdym2;
  assign rdy3  = !v3_q  || div_in_ready;
  assign rdy2  = !v2_q  || rdy3;
  assign rdy1  = !v1_q  || rdy2;
  assign in_ready_o = rdy1;

  // Stage 1: capture the word and form all edge and offset vectors. Vertex c
  // itself is rebuilt later as a plus the a-to-c vector.
  logic signed [W-1:0]  ax_q, ay_q, bx_q, by_q, px_q, py_q;
  logic [W-2:0]         r1_q;
  logic signed [DW-1:0] abx_q, aby_q, acx_q, acy_q, apx_q, apy_q;
  logic signed [DW-1:0] bpx_q, bpy_q, cpx_q, cpy_q, bcx_q, bcy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      ax_q  <= vert_a_x_i;
      ay_q  <= vert_a_y_i;
      bx_q  <= vert_b_x_i;
      by_q  <= vert_b_y_i;
      px_q  <= center_x_i;
      py_q  <= center_y_i;
      r1_q  <= radius_i;
      abx_q <= DW'(vert_b_x_i) - DW'(vert_a_x_i);
      aby_q <= DW'(vert_b_y_i) - DW'(vert_a_y_i);
      acx_q <= DW'(vert_c_x_i) - DW'(vert_a_x_i);
      acy_q <= DW'(vert_c_y_i) - DW'(vert_a_y_i);
      apx_q <= DW'(center_x_i) - DW'(vert_a_x_i);
      apy_q <= DW'(center_y_i) - DW'(vert_a_y_i);
      bpx_q <= DW'(center_x_i) - DW'(vert_b_x_i);
      bpy_q <= DW'(center_y_i) - DW'(vert_b_y_i);
      cpx_q <= DW'(center_x_i) - DW'(vert_c_x_i);
      cpy_q <= DW'(center_y_i) - DW'(vert_c_y_i);
      bcx_q <= DW'(vert_c_x_i) - DW'(vert_b_x_i);
      bcy_q <= DW'(vert_c_y_i) - DW'(vert_b_y_i);
    end
  end

  // Stage 2: signed areas for the inside test and the six dot products that
  // pick the Voronoi region. Each is two parallel multiplies and one add or subtract.
  logic signed [W-1:0]  ax2_q, ay2_q, bx2_q, by2_q, px2_q, py2_q;
  logic [W-2:0]         r2_q;
  logic signed [DW-1:0] abx2_q, aby2_q, acx2_q, acy2_q, bcx2_q, bcy2_q;
  logic signed [PW-1:0] k_q, s_q, t_q, ubc_q;
  logic signed [PW-1:0] d1_q, d2_q, d3_q, d4_q, d5_q, d6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      ax2_q  <= ax_q;
      ay2_q  <= ay_q;
      bx2_q  <= bx_q;
      by2_q  <= by_q;
      px2_q  <= px_q;
      py2_q  <= py_q;
      r2_q   <= r1_q;
      abx2_q <= abx_q;
      aby2_q <= aby_q;
      acx2_q <= acx_q;
      acy2_q <= acy_q;
      bcx2_q <= bcx_q;
      bcy2_q <= bcy_q;
      k_q    <= tcol_pkg::cross2(abx_q, acy_q, aby_q, acx_q);
      s_q    <= tcol_pkg::cross2(apx_q, acy_q, apy_q, acx_q);
      t_q    <= tcol_pkg::cross2(abx_q, apy_q, aby_q, apx_q);
      ubc_q  <= tcol_pkg::cross2(bcx_q, bpy_q, bcy_q, bpx_q);
      d1_q   <= tcol_pkg::dot2(abx_q, apx_q, aby_q, apy_q);
      d2_q   <= tcol_pkg::dot2(acx_q, apx_q, acy_q, apy_q);
      d3_q   <= tcol_pkg::dot2(abx_q, bpx_q, aby_q, bpy_q);
      d4_q   <= tcol_pkg::dot2(acx_q, bpx_q, acy_q, bpy_q);
      d5_q   <= tcol_pkg::dot2(abx_q, cpx_q, aby_q, cpy_q);
      d6_q   <= tcol_pkg::dot2(acx_q, cpx_q, acy_q, cpy_q);
    end
  end

  // Stage 3: inside test, region priority, and selection of the one edge
  // fraction that the divider must form. Vertex and inside cases use a zero
  // edge vector, so the later offset is zero and the base passes through.
  logic signed [PW:0]   st_sum;
  logic signed [NW-1:0] n13, d13, n26, d26, n43, n56, dbc;
  logic                 ins_c, le_t, le_s, le_u;
  logic signed [NW-1:0] num_c, den_c;
  tcol_pkg::pay_t       pay_c;

  function automatic logic le0(input logic signed [PW-1:0] x, input logic signed [PW-1:0] y);
    return (x == '0) || (y == '0) || (x[PW-1] != y[PW-1]);
  endfunction

  always_comb begin
    st_sum = (PW+1)'(s_q) + (PW+1)'(t_q);
    if (k_q == '0) begin
      ins_c = 1'b1;
    end else if (!k_q[PW-1]) begin
      ins_c = !s_q[PW-1] && !t_q[PW-1] && (st_sum <= (PW+1)'(k_q));
    end else begin
      ins_c = (s_q <= 0) && (t_q <= 0) && (st_sum >= (PW+1)'(k_q));
    end

    le_t = le0(k_q, t_q);
    le_s = le0(k_q, s_q);
    le_u = le0(k_q, ubc_q);
    n13  = NW'(d1_q);
    d13  = NW'(d1_q) - NW'(d3_q);
    n26  = NW'(d2_q);
    d26  = NW'(d2_q) - NW'(d6_q);
    n43  = NW'(d4_q) - NW'(d3_q);
    n56  = NW'(d5_q) - NW'(d6_q);
    dbc  = n43 + n56;

    pay_c.ins    = ins_c;
    pay_c.region = tcol_pkg::RegIn;
    pay_c.base_x = px2_q;
    pay_c.base_y = py2_q;
    pay_c.e_x    = '0;
    pay_c.e_y    = '0;
    pay_c.p_x    = px2_q;
    pay_c.p_y    = py2_q;
    pay_c.radius = r2_q;
    num_c        = '0;
    den_c        = '0;

    if (!ins_c) begin
      if (d1_q <= 0 && d2_q <= 0) begin
        pay_c.region = tcol_pkg::RegA;
        pay_c.base_x = ax2_q;
        pay_c.base_y = ay2_q;
      end else if (d3_q >= 0 && d4_q <= d3_q) begin
        pay_c.region = tcol_pkg::RegB;
        pay_c.base_x = bx2_q;
        pay_c.base_y = by2_q;
      end else if (le_t && d1_q >= 0 && d3_q <= 0) begin
        pay_c.region = tcol_pkg::RegAb;
        pay_c.base_x = ax2_q;
        pay_c.base_y = ay2_q;
        pay_c.e_x    = abx2_q;
        pay_c.e_y    = aby2_q;
        num_c        = n13;
        den_c        = d13;
      end else if (d6_q >= 0 && d5_q <= d6_q) begin
        pay_c.region = tcol_pkg::RegC;
        pay_c.base_x = ax2_q + W'(acx2_q);
        pay_c.base_y = ay2_q + W'(acy2_q);
      end else if (le_s && d2_q >= 0 && d6_q <= 0) begin
        pay_c.region = tcol_pkg::RegAc;
        pay_c.base_x = ax2_q;
        pay_c.base_y = ay2_q;
        pay_c.e_x    = acx2_q;
        pay_c.e_y    = acy2_q;
        num_c        = n26;
        den_c        = d26;
      end else if (le_u && n43 >= 0 && n56 >= 0) begin
        pay_c.region = tcol_pkg::RegBc;
        pay_c.base_x = bx2_q;
        pay_c.base_y = by2_q;
        pay_c.e_x    = bcx2_q;
        pay_c.e_y    = bcy2_q;
        num_c        = n43;
        den_c        = dbc;
      end
    end

    // Negative operands clamp to zero, as the fraction is defined on 0..1.
    if (num_c < 0) begin
      num_c = '0;
    end
    if (den_c < 0) begin
      den_c = '0;
    end
    pay_c.zero = (den_c == '0);
    pay_c.full = (den_c != '0) && (num_c >= den_c);
  end

  logic [NW-1:0]  num3_q, den3_q;
  tcol_pkg::pay_t pay3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      // A full fraction needs no division; feed the divider a harmless zero.
      num3_q <= pay_c.full ? '0 : NW'(num_c);
      den3_q <= NW'(den_c);
      pay3_q <= pay_c;
    end
  end

  // Stages 4 to 35: the fraction floor(num * 2^32 / den).
  logic [QW-1:0]  quo;
  tcol_pkg::pay_t pay_div;

  tcol_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v3_q),
    .in_ready_o  (div_in_ready),
    .num_i       (num3_q),
    .den_i       (den3_q),
    .pay_i       (pay3_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (rdym1),
    .quo_o       (quo),
    .pay_o       (pay_div)
  );

  // Stage M1: scale the edge magnitude by the fraction.
  logic [FW-1:0]  frac;
  logic [W-1:0]   mag_x, mag_y;
  logic [XW-1:0]  prx_q, pry_q;
  tcol_pkg::pay_t pm1_q;

  always_comb begin
    if (pay_div.zero) begin
      frac = '0;
    end else if (pay_div.full) begin
      frac = {1'b1, {QW{1'b0}}};
    end else begin
      frac = {1'b0, quo};
    end
    mag_x = pay_div.e_x[DW-1] ? W'(-pay_div.e_x) : W'(pay_div.e_x);
    mag_y = pay_div.e_y[DW-1] ? W'(-pay_div.e_y) : W'(pay_div.e_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm1_q <= 1'b0;
    end else if (rdym1) begin
      vm1_q <= div_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdym1 && div_out_valid) begin
      prx_q <= XW'(mag_x) * XW'(frac);
      pry_q <= XW'(mag_y) * XW'(frac);
      pm1_q <= pay_div;
    end
  end

  // Stage M2: round the offset half away from zero and apply it with the
  // edge's sign to the base point.
  logic [XW:0]         rnd_x, rnd_y;
  logic signed [DW:0]  off_x, off_y, nr_x, nr_y;
  logic signed [W-1:0] near_x_q, near_y_q;
  tcol_pkg::pay_t      pm2_q;

  always_comb begin
    rnd_x = (XW+1)'(prx_q) + (XW+1)'({1'b1, {(QW-1){1'b0}}});
    rnd_y = (XW+1)'(pry_q) + (XW+1)'({1'b1, {(QW-1){1'b0}}});
    off_x = (DW+1)'(rnd_x[XW:QW]);
    off_y = (DW+1)'(rnd_y[XW:QW]);
    nr_x  = pm1_q.e_x[DW-1] ? (DW+1)'(pm1_q.base_x) - off_x : (DW+1)'(pm1_q.base_x) + off_x;
    nr_y  = pm1_q.e_y[DW-1] ? (DW+1)'(pm1_q.base_y) - off_y : (DW+1)'(pm1_q.base_y) + off_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm2_q <= 1'b0;
    end else if (rdym2) begin
      vm2_q <= vm1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdym2 && vm1_q) begin
      near_x_q <= W'(nr_x);
      near_y_q <= W'(nr_y);
      pm2_q    <= pm1_q;
    end
  end

  // Stage M3: squared distance terms and squared radius.
  logic signed [DW-1:0] dx, dy;
  logic [W-1:0]         ux, uy;
  logic [SW-1:0]        sqx_q, sqy_q;
  logic [SW-3:0]        rr_q;
  logic signed [W-1:0]  near_x3_q, near_y3_q;
  logic                 ins3_q;
  logic [2:0]           reg3_q;

  always_comb begin
    dx = DW'(near_x_q) - DW'(pm2_q.p_x);
    dy = DW'(near_y_q) - DW'(pm2_q.p_y);
    ux = dx[DW-1] ? W'(-dx) : W'(dx);
    uy = dy[DW-1] ? W'(-dy) : W'(dy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm3_q <= 1'b0;
    end else if (rdym3) begin
      vm3_q <= vm2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdym3 && vm2_q) begin
      sqx_q     <= SW'(ux) * SW'(ux);
      sqy_q     <= SW'(uy) * SW'(uy);
      rr_q      <= (SW-2)'(pm2_q.radius) * (SW-2)'(pm2_q.radius);
      near_x3_q <= near_x_q;
      near_y3_q <= near_y_q;
      ins3_q    <= pm2_q.ins;
      reg3_q    <= pm2_q.region;
    end
  end

  // Output register: the radius compare. Inside and no-region cases report
  // the center itself with overlap set.
  logic [SW:0] dist2;

  assign dist2 = (SW+1)'(sqx_q) + (SW+1)'(sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (rdyo) begin
      vo_q <= vm3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdyo && vm3_q) begin
      overlap_o    <= (reg3_q == tcol_pkg::RegIn) || (dist2 <= (SW+1)'(rr_q));
      inside_res_o <= ins3_q;
      near_x_o     <= near_x3_q;
      near_y_o     <= near_y3_q;
      region_o     <= reg3_q;
    end
  end

  assign out_valid_o = vo_q;

endmodule
